// ===== rtl/core/pdwt_pkg.sv =====
// Shared constants, register indexes and arithmetic helpers for the wavelet block.
`default_nettype none
package pdwt_pkg;
    localparam int MAX_LOG2_LEN = 10;
    localparam int MAX_TAPS = 8;
    localparam int DEPTH = 1 << MAX_LOG2_LEN;
    localparam int AW = MAX_LOG2_LEN;
    localparam int CW = MAX_LOG2_LEN + 1;
    localparam int DW = 24;
    localparam int SW = 16;
    localparam int TW = 16;
    localparam int KW = 3;
    localparam int PW = DW + TW;
    localparam int ACCW = PW + KW;
    localparam int ADDR_W = 6;
    localparam int PDATA_W = 64;

    localparam logic [2:0] REG_LENGTH_LOG2 = 3'd0;
    localparam logic [2:0] REG_LEVELS = 3'd1;
    localparam logic [2:0] REG_FILTER_LENGTH = 3'd2;
    localparam logic [2:0] REG_LOW_TAPS_A = 3'd3;
    localparam logic [2:0] REG_LOW_TAPS_B = 3'd4;
    localparam logic [2:0] REG_HIGH_TAPS_A = 3'd5;
    localparam logic [2:0] REG_HIGH_TAPS_B = 3'd6;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    function automatic logic signed [TW-1:0] tap_sel(input logic [63:0] lo,
                                                     input logic [63:0] hi,
                                                     input logic [KW-1:0] k);
        logic [63:0] word;
        begin
            word = k[2] ? hi : lo;
            tap_sel = $signed(word[16*k[1:0] +: 16]);
        end
    endfunction

    function automatic logic signed [DW-1:0] round_sat(input logic signed [ACCW-1:0] acc);
        logic signed [ACCW:0] v;
        logic signed [ACCW-14:0] q;
        begin
            v = {acc[ACCW-1], acc} + (ACCW+1)'(8192);
            q = (ACCW-13)'(v >>> 14);
            if (q > (ACCW-13)'(8388607))
                round_sat = 24'sh7FFFFF;
            else if (q < -(ACCW-13)'(8388608))
                round_sat = 24'sh800000;
            else
                round_sat = q[DW-1:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/pdwt_in_if.sv =====
// Request channel into the wavelet block.
`default_nettype none
interface pdwt_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic signed [15:0] sample;
    logic [9:0] read_index;
    modport source (output valid, operation, sample, read_index, input ready);
    modport sink (input valid, operation, sample, read_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pdwt_out_if.sv =====
// Result channel out of the wavelet block.
`default_nettype none
interface pdwt_out_if;
    logic valid;
    logic ready;
    logic signed [23:0] coefficient;
    logic valid_res;
    modport source (output valid, coefficient, valid_res, input ready);
    modport sink (input valid, coefficient, valid_res, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/periodic_dwt_analysis_top.sv =====
// Top level of the multilevel periodic wavelet analysis block.
//
//   channel   direction   handshake          payload
//   in_ch     sink        valid/ready        operation, sample, read_index
//   out_ch    source      valid/ready        coefficient, valid_res
//   apb       slave       psel/penable       paddr, pwdata, prdata
//
// A load writes its sample into the work memory as it is accepted; a read result passes the
// registered read port of the coefficient memory and then the output register. A read holds
// off the next request while it is pending, and a read waits while a result is not taken. The
// load that completes a block starts the analysis, which holds off requests until it ends; it
// uses the single multiply-accumulate pipeline and the one read port of each sample memory.
// Reset clears the counters and control; the sample memories are not cleared.
`default_nettype none
module periodic_dwt_analysis_top (
    input  wire                            clk,
    input  wire                            rst_n,
    pdwt_in_if.sink                        in_ch,
    pdwt_out_if.source                     out_ch,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [pdwt_pkg::ADDR_W-1:0]    paddr,
    input  wire  [pdwt_pkg::PDATA_W-1:0]   pwdata,
    output logic [pdwt_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import pdwt_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_COPYIN = 3'd1;
    localparam logic [2:0] ST_CHK    = 3'd2;
    localparam logic [2:0] ST_FILT   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_COPYBK = 3'd5;
    localparam logic [2:0] ST_NEXT   = 3'd6;

    logic [3:0] length_log2_reg, levels_reg, filter_length_reg;
    logic [63:0] low_a_reg, low_b_reg, high_a_reg, high_b_reg;

    logic [DW-1:0] work_mem [DEPTH];
    logic [DW-1:0] coeff_mem [DEPTH];
    logic signed [DW-1:0] work_q_reg, coeff_q_reg;

    logic [2:0] state_reg;
    logic [CW-1:0] load_count_reg;
    logic [CW-1:0] done_len_reg;
    logic [AW-1:0] j_reg, total_m1_reg, n_m1_reg;
    logic [AW-2:0] i_reg;
    logic f_reg;
    logic [KW-1:0] k_reg, taps_m1_reg;
    logic [3:0] lvl_reg, lv_reg;

    logic cp_v_reg, cp_dir_reg;
    logic [AW-1:0] cp_addr_reg;

    logic s1_v_reg, s1_first_reg, s1_last_reg;
    logic signed [TW-1:0] s1_tap_reg;
    logic [AW-1:0] s1_dest_reg;
    logic s2_v_reg, s2_first_reg, s2_last_reg;
    logic signed [PW-1:0] s2_prod_reg;
    logic [AW-1:0] s2_dest_reg;
    logic s3_v_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic [AW-1:0] s3_dest_reg;

    logic rd_pend_reg, rd_ok_reg;
    logic out_v_reg, out_res_reg;
    logic signed [DW-1:0] out_coeff_reg;

    logic cfg_we, in_acc, load_acc, read_acc;
    logic [3:0] lg_use, taps_use, lv_use;
    logic [CW-1:0] cnt_next;
    logic [AW:0] filt_sum;
    logic [AW-1:0] filt_addr, half, work_ra, coeff_ra;
    logic work_we, coeff_we;
    logic [AW-1:0] work_wa, coeff_wa;
    logic [DW-1:0] work_wd, coeff_wd;
    logic last_k, last_i, pipe_empty;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[5:3])
            REG_LENGTH_LOG2:   prdata = {60'd0, length_log2_reg};
            REG_LEVELS:        prdata = {60'd0, levels_reg};
            REG_FILTER_LENGTH: prdata = {60'd0, filter_length_reg};
            REG_LOW_TAPS_A:    prdata = low_a_reg;
            REG_LOW_TAPS_B:    prdata = low_b_reg;
            REG_HIGH_TAPS_A:   prdata = high_a_reg;
            REG_HIGH_TAPS_B:   prdata = high_b_reg;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_log2_reg   <= 4'd10;
            levels_reg        <= 4'd1;
            filter_length_reg <= 4'd2;
            low_a_reg         <= 64'd759246145;
            low_b_reg         <= '0;
            high_a_reg        <= 64'd3535744321;
            high_b_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (paddr[5:3])
                REG_LENGTH_LOG2:   length_log2_reg <= pwdata[3:0];
                REG_LEVELS:        levels_reg <= pwdata[3:0];
                REG_FILTER_LENGTH: filter_length_reg <= pwdata[3:0];
                REG_LOW_TAPS_A:    low_a_reg <= pwdata;
                REG_LOW_TAPS_B:    low_b_reg <= pwdata;
                REG_HIGH_TAPS_A:   high_a_reg <= pwdata;
                REG_HIGH_TAPS_B:   high_b_reg <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (length_log2_reg < 4'd1)
            lg_use = 4'd1;
        else if (length_log2_reg > 4'(MAX_LOG2_LEN))
            lg_use = 4'(MAX_LOG2_LEN);
        else
            lg_use = length_log2_reg;
        lv_use = (levels_reg > lg_use) ? lg_use : levels_reg;
        if (filter_length_reg < 4'd1)
            taps_use = 4'd1;
        else if (filter_length_reg > 4'(MAX_TAPS))
            taps_use = 4'(MAX_TAPS);
        else
            taps_use = filter_length_reg;
    end

    assign in_ch.ready = (state_reg == ST_IDLE) && !rd_pend_reg &&
                         (in_ch.operation == OP_LOAD || !out_v_reg || out_ch.ready);
    assign in_acc   = in_ch.valid && in_ch.ready;
    assign load_acc = in_acc && in_ch.operation == OP_LOAD;
    assign read_acc = in_acc && in_ch.operation == OP_READ;
    assign cnt_next = load_count_reg + CW'(1);

    assign half      = {1'b0, n_m1_reg[AW-1:1]} + AW'(1);
    assign filt_sum  = {1'b0, i_reg, 1'b0} + (AW+1)'(k_reg);
    assign filt_addr = filt_sum[AW-1:0] & n_m1_reg;
    assign last_k    = k_reg == taps_m1_reg;
    assign last_i    = i_reg == n_m1_reg[AW-1:1];
    assign pipe_empty = !s1_v_reg && !s2_v_reg && !s3_v_reg;

    assign work_ra  = (state_reg == ST_COPYIN) ? j_reg : filt_addr;
    assign coeff_ra = (state_reg == ST_COPYBK) ? j_reg : in_ch.read_index;

    always_comb
    begin
        work_we = 1'b0;
        work_wa = cp_addr_reg;
        work_wd = coeff_q_reg;
        if (load_acc)
        begin
            work_we = 1'b1;
            work_wa = load_count_reg[AW-1:0];
            work_wd = DW'(in_ch.sample);
        end
        else if (cp_v_reg && cp_dir_reg)
        begin
            work_we = 1'b1;
        end
        coeff_we = 1'b0;
        coeff_wa = cp_addr_reg;
        coeff_wd = work_q_reg;
        if (cp_v_reg && !cp_dir_reg)
        begin
            coeff_we = 1'b1;
        end
        else if (s3_v_reg)
        begin
            coeff_we = 1'b1;
            coeff_wa = s3_dest_reg;
            coeff_wd = round_sat(acc_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
            work_mem[work_wa] <= work_wd;
        work_q_reg <= work_mem[work_ra];
    end

    always_ff @(posedge clk)
    begin
        if (coeff_we)
            coeff_mem[coeff_wa] <= coeff_wd;
        coeff_q_reg <= coeff_mem[coeff_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_count_reg <= '0;
            done_len_reg   <= '0;
            j_reg          <= '0;
            i_reg          <= '0;
            f_reg          <= 1'b0;
            k_reg          <= '0;
            lvl_reg        <= '0;
            lv_reg         <= '0;
            taps_m1_reg    <= '0;
            total_m1_reg   <= '0;
            n_m1_reg       <= '0;
            cp_v_reg       <= 1'b0;
            cp_dir_reg     <= 1'b0;
            s1_v_reg       <= 1'b0;
        end
        else
        begin
            cp_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (load_acc)
                    begin
                        if (cnt_next >= (CW'(1) << lg_use))
                        begin
                            load_count_reg <= '0;
                            total_m1_reg   <= AW'((CW'(1) << lg_use) - CW'(1));
                            n_m1_reg       <= AW'((CW'(1) << lg_use) - CW'(1));
                            lv_reg         <= lv_use;
                            taps_m1_reg    <= KW'(taps_use - 4'd1);
                            lvl_reg        <= '0;
                            j_reg          <= '0;
                            state_reg      <= ST_COPYIN;
                        end
                        else
                        begin
                            load_count_reg <= cnt_next;
                        end
                    end
                end
                ST_COPYIN:
                begin
                    cp_v_reg    <= 1'b1;
                    cp_dir_reg  <= 1'b0;
                    cp_addr_reg <= j_reg;
                    j_reg       <= j_reg + AW'(1);
                    if (j_reg == total_m1_reg)
                        state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    i_reg <= '0;
                    f_reg <= 1'b0;
                    k_reg <= '0;
                    if (lv_reg == 4'd0)
                    begin
                        done_len_reg <= CW'(total_m1_reg) + CW'(1);
                        state_reg    <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_FILT;
                    end
                end
                ST_FILT:
                begin
                    s1_v_reg     <= 1'b1;
                    s1_first_reg <= k_reg == '0;
                    s1_last_reg  <= last_k;
                    s1_tap_reg   <= f_reg ? tap_sel(high_a_reg, high_b_reg, k_reg)
                                          : tap_sel(low_a_reg, low_b_reg, k_reg);
                    s1_dest_reg  <= f_reg ? half + AW'(i_reg) : AW'(i_reg);
                    if (last_k)
                    begin
                        k_reg <= '0;
                        f_reg <= !f_reg;
                        if (f_reg)
                        begin
                            i_reg <= i_reg + (AW-1)'(1);
                            if (last_i)
                                state_reg <= ST_DRAIN;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + KW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    j_reg <= '0;
                    if (pipe_empty)
                        state_reg <= ST_COPYBK;
                end
                ST_COPYBK:
                begin
                    cp_v_reg    <= 1'b1;
                    cp_dir_reg  <= 1'b1;
                    cp_addr_reg <= j_reg;
                    j_reg       <= j_reg + AW'(1);
                    if (j_reg == {1'b0, n_m1_reg[AW-1:1]})
                        state_reg <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    lvl_reg  <= lvl_reg + 4'd1;
                    n_m1_reg <= {1'b0, n_m1_reg[AW-1:1]};
                    i_reg    <= '0;
                    f_reg    <= 1'b0;
                    k_reg    <= '0;
                    if (lvl_reg + 4'd1 == lv_reg)
                    begin
                        done_len_reg <= CW'(total_m1_reg) + CW'(1);
                        state_reg    <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_FILT;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_prod_reg  <= work_q_reg * s1_tap_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_dest_reg  <= s1_dest_reg;
        if (s2_v_reg)
        begin
            acc_reg <= s2_first_reg ? ACCW'(s2_prod_reg) : acc_reg + ACCW'(s2_prod_reg);
            s3_dest_reg <= s2_dest_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
            out_v_reg   <= 1'b0;
            out_res_reg <= 1'b0;
            out_coeff_reg <= '0;
        end
        else
        begin
            rd_pend_reg <= read_acc;
            if (read_acc)
                rd_ok_reg <= CW'(in_ch.read_index) < done_len_reg;
            if (rd_pend_reg)
            begin
                out_v_reg     <= 1'b1;
                out_res_reg   <= rd_ok_reg;
                out_coeff_reg <= rd_ok_reg ? coeff_q_reg : '0;
            end
            else if (out_ch.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid       = out_v_reg;
    assign out_ch.coefficient = out_coeff_reg;
    assign out_ch.valid_res   = out_res_reg;
endmodule
`default_nettype wire
